/* hdl/heq_pkg.sv */
package heq_pkg;

  localparam int BIN_W       = 8;
  localparam int BIN_COUNT   = 256;
  localparam int PIX_W       = 8;
  localparam int PCNT_W      = 24;
  localparam int REM_W       = PCNT_W + 8;
  localparam int QUOT_W      = 9;
  localparam int DIV_STEPS   = 8;
  localparam int STEP_W      = 3;
  localparam int GREY_SUM_W  = 10;
  localparam int GREY_SHIFT  = 11;
  localparam int GREY_PROD_W = GREY_SUM_W + GREY_SHIFT;

  localparam logic [GREY_SUM_W-1:0] GREY_RECIP = 10'd683;
  localparam logic [PIX_W-1:0]      LEVEL_MAX  = 8'd255;
  localparam logic [QUOT_W-1:0]     QUOT_SAT   = 9'h100;

  localparam logic OP_COUNT = 1'b0;
  localparam logic OP_MAP   = 1'b1;

  typedef struct packed {
    logic             operation;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] alpha;
    logic             last;
  } in_word_t;

  typedef struct packed {
    logic [PIX_W-1:0] out_red;
    logic [PIX_W-1:0] out_green;
    logic [PIX_W-1:0] out_blue;
    logic [PIX_W-1:0] out_alpha;
    logic             out_last;
  } out_word_t;

  // (1 + r + g + b) / 3 as a reciprocal multiply, exact for sums below 2048
  function automatic logic [BIN_W-1:0] grey_bin(input logic [PIX_W-1:0] r,
                                                 input logic [PIX_W-1:0] g,
                                                 input logic [PIX_W-1:0] b);
    logic [GREY_SUM_W-1:0]  s;
    logic [GREY_PROD_W-1:0] p;
    s = GREY_SUM_W'(r) + GREY_SUM_W'(g) + GREY_SUM_W'(b) + GREY_SUM_W'(1);
    p = GREY_PROD_W'(s) * GREY_PROD_W'(GREY_RECIP);
    return p[GREY_SHIFT +: BIN_W];
  endfunction

endpackage

/* hdl/heq_div.sv */
module heq_div #(
  parameter int COUNT_BITS = 24
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [COUNT_BITS-1:0]               count_in,
  input  logic [heq_pkg::PCNT_W-1:0]          divisor,
  output logic                                done,
  output logic [heq_pkg::QUOT_W-1:0]          quot
);

  localparam int PROD_W = COUNT_BITS + 8;
  localparam int CMP_W  = (PROD_W > heq_pkg::REM_W) ? PROD_W : heq_pkg::REM_W;
  localparam logic [heq_pkg::STEP_W-1:0] LAST_STEP = heq_pkg::STEP_W'(heq_pkg::DIV_STEPS - 1);

  localparam logic [1:0] D_IDLE = 2'd0;
  localparam logic [1:0] D_CMP  = 2'd1;
  localparam logic [1:0] D_DIV  = 2'd2;
  localparam logic [1:0] D_DONE = 2'd3;

  logic [1:0]                      st_r, st_nxt;
  logic [PROD_W-1:0]               prod_r;
  logic [heq_pkg::REM_W-1:0]       rem_r;
  logic [heq_pkg::REM_W-1:0]       dsh_r;
  logic [heq_pkg::QUOT_W-1:0]      q_r;
  logic [heq_pkg::STEP_W-1:0]      step_r;
  logic [heq_pkg::REM_W-1:0]       lim;
  logic [CMP_W-1:0]                prod_x;
  logic [CMP_W-1:0]                lim_x;
  logic                            sat;
  logic                            rem_ge;

  assign lim    = {divisor, 8'h00};
  assign prod_x = CMP_W'(prod_r);
  assign lim_x  = CMP_W'(lim);
  assign sat    = prod_x >= lim_x;
  assign rem_ge = rem_r >= dsh_r;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      D_IDLE: if (start) st_nxt = D_CMP;
      D_CMP:  st_nxt = sat ? D_DONE : D_DIV;
      D_DIV:  if (step_r == LAST_STEP) st_nxt = D_DONE;
      D_DONE: st_nxt = D_IDLE;
      default: st_nxt = D_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= D_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  // count * 255 as a shift and subtract
  always_ff @(posedge clk) begin
    if (st_r == D_IDLE && start) begin
      prod_r <= {count_in, 8'h00} - PROD_W'(count_in);
    end
    if (st_r == D_CMP) begin
      rem_r  <= heq_pkg::REM_W'(prod_r);
      dsh_r  <= heq_pkg::REM_W'(divisor) << (heq_pkg::DIV_STEPS - 1);
      step_r <= '0;
      q_r    <= sat ? heq_pkg::QUOT_SAT : '0;
    end
    if (st_r == D_DIV) begin
      if (rem_ge) begin
        rem_r <= rem_r - dsh_r;
      end
      q_r    <= {q_r[heq_pkg::QUOT_W-2:0], rem_ge};
      dsh_r  <= dsh_r >> 1;
      step_r <= step_r + 1'b1;
    end
  end

  assign done = (st_r == D_DONE);
  assign quot = q_r;

endmodule

/* hdl/histogram_equalize_rgb_top.sv */
// Two-pass histogram equalizer for RGB/RGBA pixels. Count words (operation 0) enter one per
// cycle while in_stall is low; each bins its grey level into a 256-entry count memory through
// a read-modify-write with forwarding, and gives no result. The count word with last set
// starts the table build, during which in_stall stays high: each of the 256 bins is read and
// then divided by the shift-subtract divider. Map words (operation 1) give one result each; a
// map word holds off the next input word while its blue lookup uses port b: the three lookups
// share the two read ports of the map table memory. A map word with last clears all bins at once.
// pixel_count is written through cfg_data only while no table build runs; zero acts as one.
module histogram_equalize_rgb_top #(
  parameter int COUNT_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  heq_pkg::in_word_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output heq_pkg::out_word_t            out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [heq_pkg::PCNT_W-1:0]    cfg_data
);

  localparam logic [COUNT_BITS-1:0]     COUNT_MAX = '1;
  localparam logic [heq_pkg::BIN_W-1:0] K_LAST    = '1;

  localparam logic [1:0] B_IDLE  = 2'd0;
  localparam logic [1:0] B_RD    = 2'd1;
  localparam logic [1:0] B_START = 2'd2;
  localparam logic [1:0] B_WAIT  = 2'd3;

  localparam logic [1:0] M_IDLE = 2'd0;
  localparam logic [1:0] M_RG   = 2'd1;
  localparam logic [1:0] M_B    = 2'd2;

  logic                          in_acc, cnt_acc, map_acc, clr;
  logic [heq_pkg::BIN_W-1:0]     grey;

  // bin count memory
  logic [COUNT_BITS-1:0]         bin_mem_r [heq_pkg::BIN_COUNT];
  logic [heq_pkg::BIN_COUNT-1:0] bin_vld_r;
  logic [heq_pkg::BIN_W-1:0]     bin_rd_addr;
  logic [COUNT_BITS-1:0]         bin_rd_r;
  logic                          vb_r;
  logic                          s1_vld_r, s1_last_r;
  logic [heq_pkg::BIN_W-1:0]     s1_addr_r;
  logic                          wr_vld_r;
  logic [heq_pkg::BIN_W-1:0]     wr_addr_r;
  logic [COUNT_BITS-1:0]         wr_data_r;
  logic [COUNT_BITS-1:0]         base;
  logic [COUNT_BITS-1:0]         bin_wdata;

  // table build
  logic [1:0]                    bst_r, bst_nxt;
  logic [heq_pkg::BIN_W-1:0]     k_r;
  logic [heq_pkg::PIX_W-1:0]     run_r;
  logic [heq_pkg::PIX_W+1:0]     run_sum;
  logic [heq_pkg::PIX_W-1:0]     run_nxt;
  logic [heq_pkg::PCNT_W-1:0]    pc_r;
  logic [heq_pkg::PCNT_W-1:0]    divisor;
  logic                          div_done;
  logic [heq_pkg::QUOT_W-1:0]    quot;
  logic                          map_we;

  // map table and map path
  logic [heq_pkg::PIX_W-1:0]     map_mem_r [heq_pkg::BIN_COUNT];
  logic [heq_pkg::PIX_W-1:0]     tbl_a_r, tbl_b_r;
  logic [heq_pkg::BIN_W-1:0]     tb_addr;
  logic                          tb_en;
  logic [1:0]                    mst_r, mst_nxt;
  logic [heq_pkg::PIX_W-1:0]     px_blue_r, px_alpha_r;
  logic                          px_last_r;
  logic [heq_pkg::PIX_W-1:0]     red_q_r, green_q_r;
  logic                          out_free, map_done;
  logic                          out_valid_r;
  heq_pkg::out_word_t            out_data_r;

  assign in_acc  = in_valid & ~in_stall;
  assign cnt_acc = in_acc & (in_data.operation == heq_pkg::OP_COUNT);
  assign map_acc = in_acc & (in_data.operation == heq_pkg::OP_MAP);
  assign clr     = map_acc & in_data.last;
  assign grey    = heq_pkg::grey_bin(in_data.red, in_data.green, in_data.blue);

  assign out_free = ~(out_valid_r & out_stall);
  assign map_done = (mst_r == M_B) & out_free;

  assign in_stall = ~rst_n | (bst_r != B_IDLE) | (s1_vld_r & s1_last_r) | (mst_r == M_RG) |
                    ((mst_r == M_B) & ~out_free);
  assign cfg_ready = rst_n & (bst_r == B_IDLE);

  // ---- count pass: read at accept, increment and write in the next cycle
  assign bin_rd_addr = (bst_r == B_RD) ? k_r : grey;

  assign base = (wr_vld_r && wr_addr_r == s1_addr_r) ? wr_data_r :
                (vb_r ? bin_rd_r : '0);
  assign bin_wdata = (base == COUNT_MAX) ? base : base + COUNT_BITS'(1);

  always_ff @(posedge clk) begin
    bin_rd_r <= bin_mem_r[bin_rd_addr];
    vb_r     <= bin_vld_r[bin_rd_addr];
    if (s1_vld_r) begin
      bin_mem_r[s1_addr_r] <= bin_wdata;
    end
    s1_addr_r <= grey;
    wr_addr_r <= s1_addr_r;
    wr_data_r <= bin_wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_vld_r <= '0;
      s1_vld_r  <= 1'b0;
      s1_last_r <= 1'b0;
      wr_vld_r  <= 1'b0;
    end else begin
      if (clr) begin
        bin_vld_r <= '0;
      end else if (s1_vld_r) begin
        bin_vld_r[s1_addr_r] <= 1'b1;
      end
      s1_vld_r  <= cnt_acc;
      s1_last_r <= cnt_acc & in_data.last;
      wr_vld_r  <= s1_vld_r & ~clr;
    end
  end

  // ---- table build
  assign divisor = (pc_r == '0) ? heq_pkg::PCNT_W'(1) : pc_r;
  assign map_we  = (bst_r == B_WAIT) & div_done;
  assign run_sum = (heq_pkg::PIX_W+2)'(run_r) + (heq_pkg::PIX_W+2)'(quot);
  assign run_nxt = (run_sum > (heq_pkg::PIX_W+2)'(heq_pkg::LEVEL_MAX)) ? heq_pkg::LEVEL_MAX :
                   run_sum[heq_pkg::PIX_W-1:0];

  heq_div #(
    .COUNT_BITS(COUNT_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (bst_r == B_START),
    .count_in (vb_r ? bin_rd_r : '0),
    .divisor  (divisor),
    .done     (div_done),
    .quot     (quot)
  );

  always_comb begin
    bst_nxt = bst_r;
    case (bst_r)
      B_IDLE:  if (s1_vld_r && s1_last_r) bst_nxt = B_RD;
      B_RD:    bst_nxt = B_START;
      B_START: bst_nxt = B_WAIT;
      B_WAIT:  if (div_done) bst_nxt = (k_r == K_LAST) ? B_IDLE : B_RD;
      default: bst_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bst_r <= B_IDLE;
      pc_r  <= heq_pkg::PCNT_W'(1);
    end else begin
      bst_r <= bst_nxt;
      if (cfg_valid && cfg_ready) begin
        pc_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (bst_r == B_IDLE) begin
      k_r   <= '0;
      run_r <= '0;
    end else if (map_we) begin
      k_r   <= k_r + 1'b1;
      run_r <= run_nxt;
    end
  end

  // ---- map pass: red and green lookups, then blue on port b
  assign tb_addr = (mst_r == M_RG) ? px_blue_r : in_data.green;
  assign tb_en   = (mst_r != M_B) | map_done;

  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem_r[k_r] <= run_nxt;
    end
    tbl_a_r <= map_mem_r[in_data.red];
    if (tb_en) begin
      tbl_b_r <= map_mem_r[tb_addr];
    end
  end

  always_comb begin
    mst_nxt = mst_r;
    case (mst_r)
      M_IDLE:  if (map_acc) mst_nxt = M_RG;
      M_RG:    mst_nxt = M_B;
      M_B:     if (map_done) mst_nxt = map_acc ? M_RG : M_IDLE;
      default: mst_nxt = M_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mst_r       <= M_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      mst_r <= mst_nxt;
      if (map_done) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (map_acc) begin
      px_blue_r  <= in_data.blue;
      px_alpha_r <= in_data.alpha;
      px_last_r  <= in_data.last;
    end
    if (mst_r == M_RG) begin
      red_q_r   <= tbl_a_r;
      green_q_r <= tbl_b_r;
    end
    if (map_done) begin
      out_data_r.out_red   <= red_q_r;
      out_data_r.out_green <= green_q_r;
      out_data_r.out_blue  <= tbl_b_r;
      out_data_r.out_alpha <= px_alpha_r;
      out_data_r.out_last  <= px_last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* hdl/heq_chk.sv */
module heq_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input heq_pkg::in_word_t             in_data,
  input logic                          out_valid,
  input logic                          out_stall,
  input heq_pkg::out_word_t            out_data,
  input logic                          cfg_ready
);

  logic cnt_last_acc;
  logic map_acc;

  assign cnt_last_acc = in_valid & ~in_stall & (in_data.operation == heq_pkg::OP_COUNT) &
                        in_data.last;
  assign map_acc      = in_valid & ~in_stall & (in_data.operation == heq_pkg::OP_MAP);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result word dropped or changed");

  a_build_stall: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_last_acc |=> in_stall)
    else $error("word accepted while table build starts");

  a_build_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_last_acc |-> ##2 (!cfg_ready && in_stall))
    else $error("table build not running after last count word");

  a_map_gap: assert property (@(posedge clk) disable iff (!rst_n)
    map_acc |=> in_stall)
    else $error("map word accepted back to back");

endmodule

bind histogram_equalize_rgb_top heq_chk u_heq_chk (.*);
